[src/knps_pkg.sv]
// Shared constants and types for the k-nearest point selector.
package knps_pkg;

    localparam int POINT_CAPACITY_DEF = 32;
    localparam int COORD_BITS_DEF     = 32;

    // Fixed field widths on the stream ports
    localparam int FIELD_COORD_W = 32;
    localparam int FIELD_COUNT_W = 6;
    localparam int FIELD_SLOT_W  = 5;
    localparam int KIND_W        = 2;
    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 104;

    // Most results one query may return
    localparam logic [FIELD_COUNT_W-1:0] MAX_RESULTS = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Per-cycle command broadcast along the sorting row
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

[src/knps_dist.sv]
// Point store and pipelined squared-distance unit.
module knps_dist #(
    parameter int POINT_CAPACITY = 32,
    parameter int COORD_BITS     = 32,
    parameter int ADDR_BITS      = $clog2(POINT_CAPACITY),
    parameter int DIST_BITS      = 2 * COORD_BITS + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [ADDR_BITS-1:0]         wr_addr,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  logic signed [COORD_BITS-1:0] wr_z,
    input  logic                         rd_en,
    input  logic [ADDR_BITS-1:0]         rd_addr,
    input  logic signed [COORD_BITS-1:0] qry_x,
    input  logic signed [COORD_BITS-1:0] qry_y,
    input  logic signed [COORD_BITS-1:0] qry_z,
    output logic                         cand_valid,
    output logic [DIST_BITS-1:0]         cand_dist,
    output logic [ADDR_BITS-1:0]         cand_slot,
    output logic signed [COORD_BITS-1:0] cand_x,
    output logic signed [COORD_BITS-1:0] cand_y,
    output logic signed [COORD_BITS-1:0] cand_z,
    output logic                         busy
);

    localparam int W  = COORD_BITS;
    localparam int SQ = 2 * COORD_BITS;

    logic signed [W-1:0] mem_x [POINT_CAPACITY];
    logic signed [W-1:0] mem_y [POINT_CAPACITY];
    logic signed [W-1:0] mem_z [POINT_CAPACITY];

    // stage 0: read
    logic                 rd_valid_reg;
    logic [ADDR_BITS-1:0] rd_slot_reg;
    logic signed [W-1:0]  rd_x_reg, rd_y_reg, rd_z_reg;
    // stage 1: absolute differences
    logic                 ad_valid_reg;
    logic [ADDR_BITS-1:0] ad_slot_reg;
    logic signed [W-1:0]  ad_x_reg, ad_y_reg, ad_z_reg;
    logic [W-1:0]         dx_reg, dy_reg, dz_reg;
    // stage 2: squares
    logic                 sq_valid_reg;
    logic [ADDR_BITS-1:0] sq_slot_reg;
    logic signed [W-1:0]  sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SQ-1:0]        sqx_reg, sqy_reg, sqz_reg;
    // stage 3: sum
    logic                 cd_valid_reg;
    logic [ADDR_BITS-1:0] cd_slot_reg;
    logic signed [W-1:0]  cd_x_reg, cd_y_reg, cd_z_reg;
    logic [DIST_BITS-1:0] cd_dist_reg;

    logic [W-1:0] dx_next, dy_next, dz_next;

    // |a - b| of two signed values always fits W unsigned bits
    function automatic logic [W-1:0] abs_diff(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
        logic signed [W:0] d;
        logic signed [W:0] m;
        d = (W + 1)'(a) - (W + 1)'(b);
        m = d[W] ? -d : d;
        return m[W-1:0];
    endfunction

    assign dx_next = abs_diff(rd_x_reg, qry_x);
    assign dy_next = abs_diff(rd_y_reg, qry_y);
    assign dz_next = abs_diff(rd_z_reg, qry_z);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_z[wr_addr] <= wr_z;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_z_reg <= mem_z[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_addr;

        ad_slot_reg <= rd_slot_reg;
        ad_x_reg    <= rd_x_reg;
        ad_y_reg    <= rd_y_reg;
        ad_z_reg    <= rd_z_reg;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;

        sq_slot_reg <= ad_slot_reg;
        sq_x_reg    <= ad_x_reg;
        sq_y_reg    <= ad_y_reg;
        sq_z_reg    <= ad_z_reg;
        sqx_reg     <= dx_reg * dx_reg;
        sqy_reg     <= dy_reg * dy_reg;
        sqz_reg     <= dz_reg * dz_reg;

        cd_slot_reg <= sq_slot_reg;
        cd_x_reg    <= sq_x_reg;
        cd_y_reg    <= sq_y_reg;
        cd_z_reg    <= sq_z_reg;
        cd_dist_reg <= DIST_BITS'(sqx_reg) + DIST_BITS'(sqy_reg) + DIST_BITS'(sqz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            ad_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            cd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            ad_valid_reg <= rd_valid_reg;
            sq_valid_reg <= ad_valid_reg;
            cd_valid_reg <= sq_valid_reg;
        end
    end

    assign cand_valid = cd_valid_reg;
    assign cand_dist  = cd_dist_reg;
    assign cand_slot  = cd_slot_reg;
    assign cand_x     = cd_x_reg;
    assign cand_y     = cd_y_reg;
    assign cand_z     = cd_z_reg;
    assign busy       = rd_valid_reg | ad_valid_reg | sq_valid_reg | cd_valid_reg;

endmodule

[src/knps_cell.sv]
// One cell of the sorted insertion row: holds one candidate and its distance.
module knps_cell #(
    parameter int COORD_BITS = 32,
    parameter int SLOT_BITS  = 5,
    parameter int DIST_BITS  = 2 * COORD_BITS + 2,
    parameter int PAY_BITS   = 3 * COORD_BITS + SLOT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  knps_pkg::cell_ctrl_t       ctrl,
    input  logic [DIST_BITS-1:0]       cand_dist,
    input  logic [PAY_BITS-1:0]        cand_pay,
    input  logic                       prev_valid,
    input  logic [DIST_BITS-1:0]       prev_dist,
    input  logic [PAY_BITS-1:0]        prev_pay,
    input  logic                       prev_ahead,
    input  logic                       next_valid,
    input  logic [DIST_BITS-1:0]       next_dist,
    input  logic [PAY_BITS-1:0]        next_pay,
    output logic                       valid,
    output logic [DIST_BITS-1:0]       held_dist,
    output logic [PAY_BITS-1:0]        pay,
    output logic                       ahead,
    output logic                       match
);

    import knps_pkg::*;

    logic                 valid_reg, valid_next;
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic [PAY_BITS-1:0]  pay_reg, pay_next;

    // strict compare: a tie leaves the earlier slot ahead
    assign ahead = !valid_reg || (cand_dist < dist_reg);
    assign match = valid_reg && (pay_reg[PAY_BITS-1:SLOT_BITS] == cand_pay[PAY_BITS-1:SLOT_BITS]);

    always_comb
    begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        pay_next   = pay_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert && ahead)
        begin
            if (prev_ahead)
            begin
                valid_next = prev_valid;
                dist_next  = prev_dist;
                pay_next   = prev_pay;
            end
            else
            begin
                valid_next = 1'b1;
                dist_next  = cand_dist;
                pay_next   = cand_pay;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            dist_next  = next_dist;
            pay_next   = next_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        pay_reg  <= pay_next;
    end

    assign valid     = valid_reg;
    assign held_dist = dist_reg;
    assign pay       = pay_reg;

endmodule

[src/k_nearest_point_select.sv]
// Top level of the brute-force k-nearest point selector.
//
//  channel   | dir | tdata (low bit up)                       | tuser  | tlast
//  s_axis    | in  | point_x, point_y, point_z, wanted_count   | kind   | -
//  m_axis    | out | neighbor_x, neighbor_y, neighbor_z, slot  | found  | last
//
// A query streams the store through the distance pipeline, drains it into the sorted
// row, then sends one result per cycle unless the output stalls; an empty store or zero
// count answers with a single word that has found low and last set.
// Reset clears the count and the sorted row; store contents stay undefined.
// A stalled result holds in the output register; no new word is taken until
// the current query has loaded its last result.
module k_nearest_point_select #(
    parameter int POINT_CAPACITY = knps_pkg::POINT_CAPACITY_DEF,
    parameter int COORD_BITS     = knps_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], wanted_count[101:96], zero pad
    input  logic [knps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[1:0]
    input  logic [knps_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // neighbor_x[31:0], neighbor_y[63:32], neighbor_z[95:64], neighbor_slot[100:96], zero pad
    output logic [knps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // found[0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    import knps_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int AW  = $clog2(POINT_CAPACITY);
    localparam int CW  = $clog2(POINT_CAPACITY + 1);
    localparam int DW  = 2 * COORD_BITS + 2;
    localparam int PW  = 3 * COORD_BITS + AW;
    localparam int FC  = FIELD_COORD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [FIELD_COUNT_W-1:0] limit_reg, limit_next;
    logic [FIELD_COUNT_W-1:0] sent_reg, sent_next;
    logic signed [W-1:0]      qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic                     ov_reg, ov_next;
    logic [FC-1:0]            ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [FIELD_SLOT_W-1:0]  os_reg, os_next;
    logic                     of_reg, of_next;
    logic                     ol_reg, ol_next;

    logic                     in_acc;
    kind_t                    kind;
    logic signed [W-1:0]      in_x, in_y, in_z;
    logic [FIELD_COUNT_W-1:0] in_wanted;
    logic                     out_free;
    logic [CW-1:0]            idx_inc;
    logic [FIELD_COUNT_W-1:0] sent_inc;
    logic                     is_last;

    logic                     wr_en;
    logic                     rd_en;
    logic                     cand_valid;
    logic [DW-1:0]            cand_dist;
    logic [AW-1:0]            cand_slot;
    logic signed [W-1:0]      cand_x, cand_y, cand_z;
    logic [PW-1:0]            cand_pay;
    logic                     dist_busy;

    cell_ctrl_t               ctrl;
    logic                     cell_valid [POINT_CAPACITY];
    logic [DW-1:0]            cell_dist  [POINT_CAPACITY];
    logic [PW-1:0]            cell_pay   [POINT_CAPACITY];
    logic                     cell_ahead [POINT_CAPACITY];
    logic [POINT_CAPACITY-1:0] cell_match;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign kind      = kind_t'(s_axis_tuser);
    assign in_x      = W'($signed(s_axis_tdata[FC-1:0]));
    assign in_y      = W'($signed(s_axis_tdata[2*FC-1:FC]));
    assign in_z      = W'($signed(s_axis_tdata[3*FC-1:2*FC]));
    assign in_wanted = s_axis_tdata[3*FC+FIELD_COUNT_W-1:3*FC];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !ov_reg || m_axis_tready;
    assign idx_inc       = idx_reg + CW'(1);
    assign sent_inc      = sent_reg + FIELD_COUNT_W'(1);
    assign is_last       = (sent_inc == limit_reg) || !cell_valid[1];

    assign wr_en = in_acc && (kind == KIND_ADD) && (count_reg < CW'(POINT_CAPACITY));
    assign rd_en = (state_reg == ST_SCAN);

    knps_dist #(
        .POINT_CAPACITY (POINT_CAPACITY),
        .COORD_BITS     (COORD_BITS),
        .ADDR_BITS      (AW),
        .DIST_BITS      (DW)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (count_reg[AW-1:0]),
        .wr_x       (in_x),
        .wr_y       (in_y),
        .wr_z       (in_z),
        .rd_en      (rd_en),
        .rd_addr    (idx_reg[AW-1:0]),
        .qry_x      (qx_reg),
        .qry_y      (qy_reg),
        .qry_z      (qz_reg),
        .cand_valid (cand_valid),
        .cand_dist  (cand_dist),
        .cand_slot  (cand_slot),
        .cand_x     (cand_x),
        .cand_y     (cand_y),
        .cand_z     (cand_z),
        .busy       (dist_busy)
    );

    assign cand_pay = {cand_x, cand_y, cand_z, cand_slot};

    // a later copy of coordinates already held is dropped
    assign ctrl.clear  = in_acc && (kind == KIND_QUERY);
    assign ctrl.insert = cand_valid && !(|cell_match);
    assign ctrl.shift  = (state_reg == ST_EMIT) && out_free;

    for (genvar i = 0; i < POINT_CAPACITY; i++)
    begin : g_cell
        logic          p_valid, p_ahead, n_valid;
        logic [DW-1:0] p_dist, n_dist;
        logic [PW-1:0] p_pay, n_pay;

        if (i == 0)
        begin : g_head
            assign p_valid = 1'b0;
            assign p_ahead = 1'b0;
            assign p_dist  = '0;
            assign p_pay   = '0;
        end
        else
        begin : g_body
            assign p_valid = cell_valid[i-1];
            assign p_ahead = cell_ahead[i-1];
            assign p_dist  = cell_dist[i-1];
            assign p_pay   = cell_pay[i-1];
        end

        if (i == POINT_CAPACITY - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_dist  = '0;
            assign n_pay   = '0;
        end
        else
        begin : g_mid
            assign n_valid = cell_valid[i+1];
            assign n_dist  = cell_dist[i+1];
            assign n_pay   = cell_pay[i+1];
        end

        knps_cell #(
            .COORD_BITS (COORD_BITS),
            .SLOT_BITS  (AW),
            .DIST_BITS  (DW),
            .PAY_BITS   (PW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cand_dist   (cand_dist),
            .cand_pay    (cand_pay),
            .prev_valid  (p_valid),
            .prev_dist   (p_dist),
            .prev_pay    (p_pay),
            .prev_ahead  (p_ahead),
            .next_valid  (n_valid),
            .next_dist   (n_dist),
            .next_pay    (n_pay),
            .valid       (cell_valid[i]),
            .held_dist   (cell_dist[i]),
            .pay         (cell_pay[i]),
            .ahead       (cell_ahead[i]),
            .match       (cell_match[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        limit_next = limit_reg;
        sent_next  = sent_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        qz_next    = qz_reg;
        ov_next    = ov_reg && !m_axis_tready;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        os_next    = os_reg;
        of_next    = of_reg;
        ol_next    = ol_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_ADD:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_QUERY:
                        begin
                            qx_next    = in_x;
                            qy_next    = in_y;
                            qz_next    = in_z;
                            limit_next = (in_wanted > MAX_RESULTS) ? MAX_RESULTS : in_wanted;
                            sent_next  = '0;
                            idx_next   = '0;
                            if ((count_reg == '0) || (in_wanted == '0))
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dist_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ox_next   = FC'($signed(cell_pay[0][AW+3*W-1:AW+2*W]));
                    oy_next   = FC'($signed(cell_pay[0][AW+2*W-1:AW+W]));
                    oz_next   = FC'($signed(cell_pay[0][AW+W-1:AW]));
                    os_next   = FIELD_SLOT_W'(cell_pay[0][AW-1:0]);
                    of_next   = 1'b1;
                    ol_next   = is_last;
                    sent_next = sent_inc;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ox_next    = '0;
                    oy_next    = '0;
                    oz_next    = '0;
                    os_next    = '0;
                    of_next    = 1'b0;
                    ol_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            limit_reg <= '0;
            sent_reg  <= '0;
            qx_reg    <= '0;
            qy_reg    <= '0;
            qz_reg    <= '0;
            ov_reg    <= 1'b0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            oz_reg    <= '0;
            os_reg    <= '0;
            of_reg    <= 1'b0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            limit_reg <= limit_next;
            sent_reg  <= sent_next;
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            qz_reg    <= qz_next;
            ov_reg    <= ov_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            oz_reg    <= oz_next;
            os_reg    <= os_next;
            of_reg    <= of_next;
            ol_reg    <= ol_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 3*FC - FIELD_SLOT_W)'(0), os_reg, oz_reg, oy_reg, ox_reg};
    assign m_axis_tuser  = of_reg;
    assign m_axis_tlast  = ol_reg;

endmodule
